// ===== rtl/mpsd_pkg.sv =====
package mpsd_pkg;

   localparam int MAX_SYNC_BITS = 64;
   localparam int WIN_DEPTH     = 2 * MAX_SYNC_BITS;
   localparam int IDX_W         = $clog2(WIN_DEPTH);
   localparam int CNT_W         = $clog2(MAX_SYNC_BITS + 1);
   localparam int FILL_W        = $clog2(WIN_DEPTH + 1);

   localparam int SYNC_W        = 7;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [SYNC_W-1:0] SYNC_BITS_RESET = 7'd32;
   localparam logic              REG_SYNC_BITS   = 1'b0;

   typedef logic [1:0] diff_type;

   localparam diff_type DIFF_ZERO = 2'b00;
   localparam diff_type DIFF_POS  = 2'b01;
   localparam diff_type DIFF_NEG  = 2'b11;

endpackage

// ===== rtl/manchester_phase_sync_decoder_top.sv =====
// Manchester phase-sync decoder.
// Input channel req_: one hard symbol per transaction (req_symbol, low bit used).
// Result channel rsp_: one decoded bit (rsp_bit_value) with an erasure flag
// (rsp_erased) for every second difference once the window is full.
// Configuration: APB write of sync_bits at byte address 0 sets the half window
// length N (0 acts as 1, above 64 acts as 64) and restarts the decoder.
// Throughput is one symbol per cycle while req_stall is low. The difference
// window sits in a 128 x 2 single-write memory; the next position's entry is
// read ahead into a register, so each symbol takes one read-modify-write slot
// and the next symbol may follow in the next cycle. A result appears in the
// output register on the cycle after the symbol that completes a pair is taken.
// Reset (synchronous, active high) sets sync_bits to 32, resets all counters and
// marks every window entry as +1 through per-entry valid flags; no clearing pass
// is needed and symbols are taken from the first cycle after reset.
// While rsp_stall holds a waiting result, req_stall is raised and the input
// channel holds; the result register keeps its value until taken.
module manchester_phase_sync_decoder_top
   import mpsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_symbol,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_bit_value,
   output logic                  rsp_erased,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   function automatic logic [CNT_W-1:0] clamp_half(input logic [SYNC_W-1:0] raw);
      logic [CNT_W-1:0] res;
      if (raw == '0) begin
         res = CNT_W'(1);
      end else if (32'(raw) > MAX_SYNC_BITS) begin
         res = CNT_W'(MAX_SYNC_BITS);
      end else begin
         res = CNT_W'(raw);
      end
      return res;
   endfunction

   logic [SYNC_W-1:0]    sync_ff, sync_in;
   logic                 prev_ff, prev_in;
   logic                 have_prev_ff, have_prev_in;
   logic [FILL_W-1:0]    fill_left_ff, fill_left_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     err_even_ff, err_even_in;
   logic [CNT_W-1:0]     err_odd_ff, err_odd_in;
   logic                 phase_ff, phase_in;
   logic [CNT_W-1:0]     rollout_ff, rollout_in;
   logic                 second_ff, second_in;
   diff_type             first_ff, first_in;
   logic [WIN_DEPTH-1:0] valid_ff, valid_in;
   diff_type             rdata_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_bit_ff, rsp_bit_in;
   logic                 rsp_erased_ff, rsp_erased_in;

   diff_type             win_mem [WIN_DEPTH];

   logic                 cfg_wr;
   logic                 accept;
   logic                 push;
   diff_type             diff;
   diff_type             old_diff;
   diff_type             out_diff;
   logic                 old_nz;
   logic                 diff_nz;
   logic [CNT_W-1:0]     half;
   logic [FILL_W-1:0]    win_len;
   logic [IDX_W-1:0]     len_m1;
   logic [CNT_W-1:0]     even_pushed;
   logic [CNT_W-1:0]     odd_pushed;
   logic [CNT_W-1:0]     err_max;
   logic                 oos_pre;
   logic                 oos_post;
   logic                 out_load;

   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_SYNC_BITS) ? CSR_DATA_W'(sync_ff) : '0;
   assign cfg_wr    = psel & penable & pwrite & (paddr[2] == REG_SYNC_BITS);

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign push      = accept & have_prev_ff;

   assign half      = clamp_half(sync_ff);
   assign win_len   = FILL_W'(half) << 1;
   assign len_m1    = IDX_W'(win_len - 1'b1);

   always_comb begin
      if (req_symbol == prev_ff) begin
         diff = DIFF_ZERO;
      end else if (req_symbol) begin
         diff = DIFF_POS;
      end else begin
         diff = DIFF_NEG;
      end
   end

   assign old_diff    = valid_ff[idx_ff] ? rdata_ff : DIFF_POS;
   assign old_nz      = (old_diff != DIFF_ZERO);
   assign diff_nz     = (diff != DIFF_ZERO);
   assign even_pushed = err_even_ff + CNT_W'(~idx_ff[0] & old_nz)
                        - CNT_W'(~idx_ff[0] & diff_nz);
   assign odd_pushed  = err_odd_ff + CNT_W'(idx_ff[0] & old_nz)
                        - CNT_W'(idx_ff[0] & diff_nz);
   assign err_max     = (err_even_ff > err_odd_ff) ? err_even_ff : err_odd_ff;
   assign oos_pre     = phase_ff ? (err_even_ff < err_odd_ff) : (err_even_ff > err_odd_ff);
   assign oos_post    = phase_ff ? (even_pushed < odd_pushed) : (even_pushed > odd_pushed);
   assign out_diff    = phase_ff ? old_diff : first_ff;

   always_comb begin
      sync_in       = sync_ff;
      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      fill_left_in  = fill_left_ff;
      idx_in        = idx_ff;
      err_even_in   = err_even_ff;
      err_odd_in    = err_odd_ff;
      phase_in      = phase_ff;
      rollout_in    = rollout_ff;
      second_in     = second_ff;
      first_in      = first_ff;
      valid_in      = valid_ff;
      out_load      = 1'b0;
      rsp_bit_in    = rsp_bit_ff;
      rsp_erased_in = rsp_erased_ff;

      if (cfg_wr) begin
         sync_in      = pwdata[SYNC_W-1:0];
         have_prev_in = 1'b0;
         prev_in      = 1'b0;
         fill_left_in = FILL_W'(clamp_half(pwdata[SYNC_W-1:0])) << 1;
         idx_in       = '0;
         err_even_in  = '0;
         err_odd_in   = '0;
         phase_in     = 1'b0;
         rollout_in   = '0;
         second_in    = 1'b0;
         first_in     = DIFF_ZERO;
         valid_in     = '0;
      end else if (accept) begin
         prev_in      = req_symbol;
         have_prev_in = 1'b1;
         if (push) begin
            idx_in           = (idx_ff == len_m1) ? '0 : idx_ff + 1'b1;
            err_even_in      = even_pushed;
            err_odd_in       = odd_pushed;
            valid_in[idx_ff] = 1'b1;
            if (fill_left_ff != '0) begin
               fill_left_in = fill_left_ff - 1'b1;
               if (fill_left_ff == FILL_W'(1) && oos_post) begin
                  phase_in = ~phase_ff;
               end
            end else if (!second_ff) begin
               if (rollout_ff == '0 && oos_pre) begin
                  if (err_max >= half) begin
                     phase_in = ~phase_ff;
                  end else begin
                     rollout_in = half - err_max;
                  end
               end
               first_in  = old_diff;
               second_in = 1'b1;
            end else begin
               second_in     = 1'b0;
               out_load      = 1'b1;
               rsp_bit_in    = (out_diff == DIFF_POS);
               rsp_erased_in = !(out_diff == DIFF_POS || out_diff == DIFF_NEG);
               if (rollout_ff != '0) begin
                  rollout_in = rollout_ff - 1'b1;
                  if (rollout_ff == CNT_W'(1) && oos_post) begin
                     phase_in = ~phase_ff;
                  end
               end
            end
         end
      end
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (push && !cfg_wr) begin
         win_mem[idx_ff] <= diff;
      end
      rdata_ff <= win_mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff      <= SYNC_BITS_RESET;
         have_prev_ff <= 1'b0;
         fill_left_ff <= FILL_W'(clamp_half(SYNC_BITS_RESET)) << 1;
         idx_ff       <= '0;
         err_even_ff  <= '0;
         err_odd_ff   <= '0;
         phase_ff     <= 1'b0;
         rollout_ff   <= '0;
         second_ff    <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sync_ff      <= sync_in;
         have_prev_ff <= have_prev_in;
         fill_left_ff <= fill_left_in;
         idx_ff       <= idx_in;
         err_even_ff  <= err_even_in;
         err_odd_ff   <= err_odd_in;
         phase_ff     <= phase_in;
         rollout_ff   <= rollout_in;
         second_ff    <= second_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff       <= prev_in;
      first_ff      <= first_in;
      rsp_bit_ff    <= rsp_bit_in;
      rsp_erased_ff <= rsp_erased_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bit_value = rsp_bit_ff;
   assign rsp_erased    = rsp_erased_ff;

   a_err_bound: assert property (@(posedge clock) disable iff (reset)
      err_even_ff <= half && err_odd_ff <= half)
      else $error("error count exceeds half window");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= len_m1)
      else $error("window index beyond window length");

   a_emit_phase: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (fill_left_ff == '0 && second_ff))
      else $error("result emitted outside second difference of a pair");

   a_rollout_bound: assert property (@(posedge clock) disable iff (reset)
      rollout_ff < half || rollout_ff == '0)
      else $error("rollout count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_bit_ff)
                                        && $stable(rsp_erased_ff)))
      else $error("waiting result overwritten");

endmodule
